FILE: hw/rtl/block_rms_envelope_assert.svh
// Assertion macros shared by the RMS envelope modules.
// Each macro takes a label, the clock, the active-low reset and the two
// halves of an implication; the checks compile away under SYNTHESIS.
`ifndef BLOCK_RMS_ENVELOPE_ASSERT_SVH
`define BLOCK_RMS_ENVELOPE_ASSERT_SVH
`ifndef SYNTHESIS
`define RMSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmse: same-cycle check failed");
`define RMSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmse: next-cycle check failed");
`else
`define RMSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RMSE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/rmse_pkg.sv
package rmse_pkg;

    localparam int SUM_W      = 48;
    localparam int FILL_W     = 20;
    localparam int BLK_W      = 12;
    localparam int POS_W      = 32;
    localparam int LVL_W      = 16;
    localparam int SPB_W      = 16;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int OUT_DATA_W = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};
    localparam logic [LVL_W-1:0]  LVL_MAX  = {LVL_W{1'b1}};

    localparam logic [SPB_W-1:0] SPB_RESET    = 16'd266;
    localparam logic [BLK_W-1:0] BLOCKS_RESET = 12'd240;

    localparam logic REG_IDX_SPB    = 1'b0;
    localparam logic REG_IDX_BLOCKS = 1'b1;

    typedef struct packed {
        logic [SPB_W-1:0] samples_per_block;
        logic [BLK_W-1:0] block_count;
    } rmse_cfg_t;

    typedef struct packed {
        logic              final_block;
        logic [FILL_W-1:0] fill;
        logic [SUM_W-1:0]  sum;
        logic [POS_W-1:0]  start_sample;
        logic [BLK_W-1:0]  block_index;
    } rmse_job_t;

endpackage

FILE: hw/rtl/rmse_front.sv
module rmse_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rmse_pkg::rmse_cfg_t     cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] in_sample,
    input  logic                    in_last,
    input  logic                    q_full,
    output logic                    push,
    output rmse_pkg::rmse_job_t     push_job
);
    import rmse_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_WIDTH;

    logic [SQ_W-1:0]         sq_reg;
    logic                    last_reg;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic                    accept;
    logic                    proc;

    logic [SUM_W-1:0]  sum_reg,   sum_next;
    logic [FILL_W-1:0] fill_reg,  fill_next;
    logic [BLK_W-1:0]  cur_reg,   cur_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;

    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_acc;
    logic [FILL_W-1:0]  fill_acc;
    logic [POS_W-1:0]   pos_acc;
    logic [SPB_W-1:0]   per_eff;
    logic [BLK_W-1:0]   blocks_eff;
    logic               block_full;

    // Stage one squares the magnitude; stage two accumulates and closes blocks.
    assign proc     = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || proc;
    assign accept   = in_valid && in_ready;
    assign mag      = in_sample[SAMPLE_WIDTH-1] ? (~in_sample + 1'b1) : in_sample;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg   <= SQ_W'(mag) * SQ_W'(mag);
            last_reg <= in_last;
        end
    end

    assign per_eff    = (cfg.samples_per_block == '0) ? SPB_W'(1) : cfg.samples_per_block;
    assign blocks_eff = (cfg.block_count == '0) ? BLK_W'(1) : cfg.block_count;

    assign sum_wide   = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign sum_acc    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign fill_acc   = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
    assign pos_acc    = pos_reg + 1'b1;
    assign block_full = (({1'b0, cur_reg} + (BLK_W + 1)'(1)) < {1'b0, blocks_eff})
                        && (fill_acc >= FILL_W'(per_eff));

    always_comb
    begin
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        push       = 1'b0;

        push_job.final_block  = last_reg;
        push_job.fill         = fill_acc;
        push_job.sum          = sum_acc;
        push_job.start_sample = start_reg;
        push_job.block_index  = cur_reg;

        if (proc)
        begin
            if (last_reg)
            begin
                push       = 1'b1;
                sum_next   = '0;
                fill_next  = '0;
                cur_next   = '0;
                start_next = '0;
                pos_next   = '0;
            end
            else if (block_full)
            begin
                push       = 1'b1;
                sum_next   = '0;
                fill_next  = '0;
                cur_next   = cur_reg + 1'b1;
                start_next = pos_acc;
                pos_next   = pos_acc;
            end
            else
            begin
                sum_next  = sum_acc;
                fill_next = fill_acc;
                pos_next  = pos_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            fill_reg  <= '0;
            cur_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            cur_reg   <= cur_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: hw/rtl/rmse_queue.sv
`include "block_rms_envelope_assert.svh"

module rmse_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rmse_pkg::rmse_job_t push_job,
    input  logic                pop,
    output rmse_pkg::rmse_job_t pop_job,
    output logic                full,
    output logic                empty
);
    import rmse_pkg::*;

    rmse_job_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `RMSE_ASSERT_IMP(a_no_push_when_full, clk, rst_n, full, !push)
    `RMSE_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, empty, !pop)

endmodule

FILE: hw/rtl/rmse_back.sv
`include "block_rms_envelope_assert.svh"

module rmse_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  rmse_pkg::rmse_job_t           pop_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rmse_pkg::BLK_W-1:0]    out_block_index,
    output logic [rmse_pkg::POS_W-1:0]    out_start_sample,
    output logic [rmse_pkg::LVL_W-1:0]    out_rms_level,
    output logic                          out_final_block
);
    import rmse_pkg::*;

    localparam int CNT_W = 6;
    localparam int SREM_W = ROOT_W + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [SUM_W-1:0]  dvd_reg,   dvd_next;
    logic [FILL_W-1:0] div_reg,   div_next;
    logic [FILL_W-1:0] rem_reg,   rem_next;
    logic [SREM_W-1:0] srem_reg,  srem_next;
    logic [ROOT_W-1:0] root_reg,  root_next;
    logic [BLK_W-1:0]  idx_reg,   idx_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic              fin_reg,   fin_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;

    logic [FILL_W:0]   rem_sh;
    logic              div_ge;
    logic [SREM_W+1:0] srem_t;
    logic [SREM_W+1:0] trial;
    logic              sqrt_ge;
    logic [LVL_W-1:0]  lvl;

    // Restoring division, one quotient bit a cycle, then a digit-by-digit
    // square root, one root bit a cycle, both on the same shift register.
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge  = rem_sh >= {1'b0, div_reg};
    assign srem_t  = {srem_reg, dvd_reg[SUM_W-1:SUM_W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sqrt_ge = srem_t >= trial;
    assign lvl     = (root_reg[ROOT_W-1:LVL_W] != '0) ? LVL_MAX : root_reg[LVL_W-1:0];

    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        idx_next   = idx_reg;
        start_next = start_reg;
        fin_next   = fin_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    dvd_next   = pop_job.sum;
                    div_next   = (pop_job.fill == '0) ? FILL_W'(1) : pop_job.fill;
                    rem_next   = '0;
                    cnt_next   = '0;
                    idx_next   = pop_job.block_index;
                    start_next = pop_job.start_sample;
                    fin_next   = pop_job.final_block;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? FILL_W'(rem_sh - {1'b0, div_reg}) : rem_sh[FILL_W-1:0];
                dvd_next = {dvd_reg[SUM_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    cnt_next   = '0;
                    srem_next  = '0;
                    root_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                srem_next = sqrt_ge ? SREM_W'(srem_t - trial) : srem_t[SREM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sqrt_ge};
                dvd_next  = {dvd_reg[SUM_W-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        idx_reg   <= idx_next;
        start_reg <= start_next;
        fin_reg   <= fin_next;
        if (out_load)
        begin
            out_block_index  <= idx_reg;
            out_start_sample <= start_reg;
            out_rms_level    <= lvl;
            out_final_block  <= fin_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `RMSE_ASSERT_IMP(a_div_rem_below_divisor, clk, rst_n, state_reg == ST_DIV,
                     (div_reg != '0) && (rem_reg < div_reg))
    `RMSE_ASSERT_IMP(a_sqrt_count_in_range, clk, rst_n, state_reg == ST_SQRT,
                     cnt_reg < CNT_W'(ROOT_W))
    `RMSE_ASSERT_NXT(a_load_shows_result, clk, rst_n, out_load,
                     out_valid_reg && (state_reg == ST_IDLE))

endmodule

FILE: hw/rtl/block_rms_envelope.sv
// Blockwise RMS envelope of a stream of signed audio samples.
// Input stream: s_axis_tdata carries one sample in its low SAMPLE_WIDTH bits
// and s_axis_tlast marks the final sample of the signal. Output stream:
// m_axis_tdata carries the block number, the position of the block's first
// sample and its RMS level; m_axis_tlast marks the result that closes the
// signal. Two registers on the APB port set the block length (address 0)
// and the number of blocks (address 4); the user must see that they are
// written only while idle, as the block itself does not enforce it.
// Samples are taken at one item per cycle while the job queue is not full:
// a square stage and an accumulate stage hand each closed block to a
// four-entry job queue. The back end pops one job at a time, divides its
// sum by the sample count and takes the square root, and pops the next job
// only once the result is loaded into the output register. Short blocks
// can thus fill the queue, and the input then waits until a job is popped.
// When the receiver stalls, the finished result stays in the output
// register while the next job is computed and the front accepts while the
// queue has room. Reset clears the accumulator, counters and queue and
// loads the default register values: 266 samples per block and 240 blocks.
module block_rms_envelope #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // block_index, start_sample, rms_level, zero padding
    output logic [rmse_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rmse_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rmse_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rmse_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rmse_pkg::*;

    localparam int PAD_W = OUT_DATA_W - BLK_W - POS_W - LVL_W;

    logic [SPB_W-1:0] spb_reg;
    logic [BLK_W-1:0] blocks_reg;
    logic             cfg_write;
    logic             reg_idx;
    rmse_cfg_t        cfg;

    logic      push;
    rmse_job_t push_job;
    logic      pop;
    rmse_job_t pop_job;
    logic      q_full;
    logic      q_empty;

    logic [BLK_W-1:0] out_block_index;
    logic [POS_W-1:0] out_start_sample;
    logic [LVL_W-1:0] out_rms_level;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg    <= SPB_RESET;
            blocks_reg <= BLOCKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_IDX_SPB:    spb_reg    <= pwdata[SPB_W-1:0];
                REG_IDX_BLOCKS: blocks_reg <= pwdata[BLK_W-1:0];
                default:        spb_reg    <= spb_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IDX_SPB:    prdata = APB_DATA_W'(spb_reg);
            REG_IDX_BLOCKS: prdata = APB_DATA_W'(blocks_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.samples_per_block = spb_reg;
    assign cfg.block_count       = blocks_reg;

    rmse_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    rmse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    rmse_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .pop_job          (pop_job),
        .pop              (pop),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_block_index  (out_block_index),
        .out_start_sample (out_start_sample),
        .out_rms_level    (out_rms_level),
        .out_final_block  (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_rms_level, out_start_sample, out_block_index};

endmodule
